### rtl/tnf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnf_pkg
// Shared types and constants for the ternary non-overlap filter.
// ----------------------------------------------------------------------------
package tnf_pkg;

   localparam int RULE_WIDTH_DEF = 64;
   localparam int MAX_KEPT_DEF   = 1024;
   localparam int FIELD_W        = 64;
   localparam int SLOT_W         = 10;
   localparam int TOTAL_W        = 11;
   localparam int REQ_DATA_W     = 2 * FIELD_W;
   localparam int RSP_DATA_W     = 24;

   typedef enum logic [1:0] {
      DEC_OVERLAP = 2'd0,
      DEC_KEPT    = 2'd1,
      DEC_FULL    = 2'd2
   } decision_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 valid;
      decision_type         decision;
      logic [SLOT_W-1:0]    slot;
      logic [TOTAL_W-1:0]   total;
   } result_type;

endpackage

### rtl/tnf_rule_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnf_rule_mem
// Kept rule store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tnf_rule_mem #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tnf_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnf_seq
// Scan sequencer: walks the kept table one entry per cycle through a single
// masked overlap comparator, then keeps, rejects or flags the rule.
// ----------------------------------------------------------------------------
module tnf_seq #(
   parameter int RULE_WIDTH = 64,
   parameter int MAX_KEPT   = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic                                   in_start,
   input  logic [RULE_WIDTH-1:0]                  in_value,
   input  logic [RULE_WIDTH-1:0]                  in_care,
   input  logic [RULE_WIDTH-1:0]                  mask,
   input  logic                                   out_free,
   output tnf_pkg::result_type                    result,
   output logic                                   mem_wr_en,
   output logic [$clog2(MAX_KEPT)-1:0]            mem_wr_addr,
   output logic [2*RULE_WIDTH-1:0]                mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [$clog2(MAX_KEPT)-1:0]            mem_rd_addr,
   input  logic [2*RULE_WIDTH-1:0]                mem_rd_data
);

   import tnf_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEPT);
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic [IDX_W-1:0]   cidx_ff, cidx_in;
   logic               issue_ff, issue_in;
   logic               dv_ff, dv_in;
   logic               last_ff, last_in;
   logic               hit_ff, hit_in;
   logic [RULE_WIDTH-1:0] value_ff, value_in;
   logic [RULE_WIDTH-1:0] care_ff, care_in;

   logic               accept;
   logic [CNT_W-1:0]   count_eff;
   logic               at_last;
   logic               cmp_hit;
   logic               keep;
   logic [RULE_WIDTH-1:0] differ;

   assign accept    = in_valid && in_ready;
   assign count_eff = in_start ? '0 : count_ff;
   assign at_last   = (CNT_W'(addr_ff) == count_ff - CNT_W'(1));
   assign differ    = (mem_rd_data[RULE_WIDTH-1:0] ^ value_ff)
                    & mem_rd_data[2*RULE_WIDTH-1:RULE_WIDTH] & care_ff & mask;
   assign cmp_hit   = dv_ff && (differ == '0);
   assign keep      = !hit_ff && (count_ff != CNT_MAX);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (count_eff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_hit || (dv_ff && last_ff)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      in_ready        = 1'b0;
      count_in        = count_ff;
      addr_in         = addr_ff;
      cidx_in         = cidx_ff;
      issue_in        = 1'b0;
      dv_in           = 1'b0;
      last_in         = 1'b0;
      hit_in          = hit_ff;
      value_in        = value_ff;
      care_in         = care_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = count_ff[IDX_W-1:0];
      mem_wr_data     = {care_ff, value_ff};
      mem_rd_en       = 1'b0;
      mem_rd_addr     = addr_ff;
      result.valid    = 1'b0;
      result.decision = DEC_OVERLAP;
      result.slot     = SLOT_W'(cidx_ff);
      result.total    = TOTAL_W'(count_ff);
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (accept) begin
               count_in = count_eff;
               addr_in  = '0;
               issue_in = (count_eff != '0);
               hit_in   = 1'b0;
               value_in = in_value;
               care_in  = in_care;
            end
         end
         ST_SCAN: begin
            mem_rd_en = issue_ff;
            addr_in   = addr_ff + IDX_W'(1);
            issue_in  = issue_ff && !at_last;
            dv_in     = issue_ff;
            last_in   = issue_ff && at_last;
            if (dv_ff) begin
               cidx_in = cidx_ff + IDX_W'(1);
            end else begin
               cidx_in = '0;
            end
            if (cmp_hit) begin
               hit_in   = 1'b1;
               cidx_in  = cidx_ff;
               issue_in = 1'b0;
               dv_in    = 1'b0;
            end
         end
         ST_DONE: begin
            if (hit_ff) begin
               result.decision = DEC_OVERLAP;
               result.slot     = SLOT_W'(cidx_ff);
            end else if (!keep) begin
               result.decision = DEC_FULL;
               result.slot     = '0;
            end else begin
               result.decision = DEC_KEPT;
               result.slot     = SLOT_W'(count_ff);
               result.total    = TOTAL_W'(count_ff + CNT_W'(1));
            end
            if (out_free) begin
               result.valid = 1'b1;
               mem_wr_en    = keep;
               if (keep) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= 1'b0;
         dv_ff    <= 1'b0;
         last_ff  <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         dv_ff    <= dv_in;
         last_ff  <= last_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      cidx_ff  <= cidx_in;
      value_ff <= value_in;
      care_ff  <= care_in;
   end

endmodule

### rtl/ternary_nonoverlap_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_nonoverlap_filter
// Keeps a greedy set of mutually non-overlapping ternary rules.
//
// Rules enter on the req_ stream: tdata carries value and care words, tuser
// the start flag that empties the kept table before the rule is handled.
// Each rule is compared under csr_data's mask against every kept rule, one
// table entry per cycle through a single comparator on the read port of the
// rule memory. The scan stops at the first kept rule that overlaps, and an
// empty table is not scanned at all.
// req_tready is high only between items.
// The rsp_ stream returns one item per rule: tuser is the decision, tdata the
// slot and the kept total. A registered output stage holds the result while
// rsp_tready is low; the next rule is accepted and scanned meanwhile and
// waits at its end until the stage frees up.
// Reset empties the table (no clearing pass) and sets the mask to all ones.
// The mask is written on the csr_ channel, always ready; the user must write it only while idle (not enforced here).
// ----------------------------------------------------------------------------
module ternary_nonoverlap_filter #(
   parameter int RULE_WIDTH = tnf_pkg::RULE_WIDTH_DEF,
   parameter int MAX_KEPT   = tnf_pkg::MAX_KEPT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [tnf_pkg::REQ_DATA_W-1:0] req_tdata,  // rule_value, rule_care
   input  logic                           req_tuser,  // start_run
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tnf_pkg::RSP_DATA_W-1:0] rsp_tdata,  // slot, kept_total, pad
   output logic [1:0]                     rsp_tuser,  // decision
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tnf_pkg::FIELD_W-1:0]    csr_data    // compare_mask
);

   import tnf_pkg::*;

   localparam int IDX_W = $clog2(MAX_KEPT);

   logic [RULE_WIDTH-1:0] mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_ff, rsp_in;
   result_type            result;
   logic                  out_free;

   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic [2*RULE_WIDTH-1:0] mem_wr_data;
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic [2*RULE_WIDTH-1:0] mem_rd_data;

   assign csr_ready = 1'b1;
   assign mask_in   = (csr_valid && csr_ready) ? csr_data[RULE_WIDTH-1:0] : mask_ff;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = result.valid ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.decision;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - TOTAL_W){1'b0}}, rsp_ff.total, rsp_ff.slot};

   tnf_seq #(
      .RULE_WIDTH (RULE_WIDTH),
      .MAX_KEPT   (MAX_KEPT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_start    (req_tuser),
      .in_value    (req_tdata[RULE_WIDTH-1:0]),
      .in_care     (req_tdata[FIELD_W+RULE_WIDTH-1:FIELD_W]),
      .mask        (mask_ff),
      .out_free    (out_free),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tnf_rule_mem #(
      .WIDTH (2 * RULE_WIDTH),
      .DEPTH (MAX_KEPT)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule
